FILE: sv/bfpc_pkg.sv
// ----------------------------------------------------------------------------
// Post class checker package
// Shared widths and types for the Post closed class checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bfpc_pkg;

  localparam int NUM_VARS_W = 3;
  localparam int TT_W       = 16;

  // Bit 0 is T0, bit 1 is T1, bit 2 is S, bit 3 is M and bit 4 is L.
  typedef struct packed {
    logic l;
    logic m;
    logic s;
    logic t1;
    logic t0;
  } class_flags_t;

  localparam class_flags_t ALL_CLASSES = '{l: 1'b1, m: 1'b1, s: 1'b1, t1: 1'b1, t0: 1'b1};

endpackage : bfpc_pkg

`default_nettype wire

FILE: sv/bfpc_if.sv
// ----------------------------------------------------------------------------
// Post class checker channels
// Valid/ready channel interfaces for function items and class results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface bfpc_in_if;
  import bfpc_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [NUM_VARS_W-1:0] num_vars;
  logic [TT_W-1:0]       truth_table;
  logic                  new_system;

  modport source (output valid, num_vars, truth_table, new_system, input ready);
  modport sink   (input valid, num_vars, truth_table, new_system, output ready);
endinterface : bfpc_in_if

interface bfpc_out_if;
  logic valid;
  logic ready;
  logic in_t0;
  logic in_t1;
  logic in_s;
  logic in_m;
  logic in_l;
  logic all_t0;
  logic all_t1;
  logic all_s;
  logic all_m;
  logic all_l;
  logic system_complete;

  modport source (output valid, in_t0, in_t1, in_s, in_m, in_l, all_t0, all_t1, all_s,
                  all_m, all_l, system_complete, input ready);
  modport sink   (input valid, in_t0, in_t1, in_s, in_m, in_l, all_t0, all_t1, all_s,
                  all_m, all_l, system_complete, output ready);
endinterface : bfpc_out_if

`default_nettype wire

FILE: sv/bfpc_classify.sv
// ----------------------------------------------------------------------------
// Post class classifier
// Combinational test of one truth table against the five Post classes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bfpc_classify #(
  parameter int MAX_VARS = 4
) (
  input  logic [bfpc_pkg::NUM_VARS_W-1:0] num_vars,
  input  logic [bfpc_pkg::TT_W-1:0]       truth_table,
  output bfpc_pkg::class_flags_t          flags
);
  import bfpc_pkg::*;

  localparam int TW = 1 << MAX_VARS;
  localparam int CW = (TW < TT_W) ? TW : TT_W;

  logic [TW-1:0]         tt_ext;
  logic [NUM_VARS_W-1:0] n_eff;
  class_flags_t          fk [1:MAX_VARS];

  always_comb begin
    tt_ext         = '0;
    tt_ext[CW-1:0] = truth_table[CW-1:0];
  end

  always_comb begin
    if (num_vars == '0) begin
      n_eff = NUM_VARS_W'(1);
    end else if (num_vars > NUM_VARS_W'(MAX_VARS)) begin
      n_eff = NUM_VARS_W'(MAX_VARS);
    end else begin
      n_eff = num_vars;
    end
  end

  for (genvar k = 1; k <= MAX_VARS; k++) begin : g_size
    localparam int SZ = 1 << k;

    logic [SZ-1:0] t;
    logic [SZ-1:0] anf [0:k];
    logic          s_ok;
    logic          m_ok;
    logic          l_ok;

    assign t = tt_ext[SZ-1:0];

    always_comb begin
      s_ok = 1'b1;
      m_ok = 1'b1;
      for (int i = 0; i < SZ; i++) begin
        if (t[i] == t[SZ-1-i]) begin
          s_ok = 1'b0;
        end
        for (int b = 0; b < k; b++) begin
          if (((i >> b) & 1) == 0 && t[i] && !t[i | (1 << b)]) begin
            m_ok = 1'b0;
          end
        end
      end
    end

    // Moebius transform, one stage per variable.
    always_comb begin
      anf[0] = t;
      for (int b = 0; b < k; b++) begin
        for (int i = 0; i < SZ; i++) begin
          if ((i & (1 << b)) != 0) begin
            anf[b+1][i] = anf[b][i] ^ anf[b][i ^ (1 << b)];
          end else begin
            anf[b+1][i] = anf[b][i];
          end
        end
      end
    end

    always_comb begin
      l_ok = 1'b1;
      for (int i = 0; i < SZ; i++) begin
        if ($countones(i) >= 2 && anf[k][i]) begin
          l_ok = 1'b0;
        end
      end
    end

    assign fk[k] = '{l: l_ok, m: m_ok, s: s_ok, t1: t[SZ-1], t0: !t[0]};
  end

  always_comb begin
    flags = fk[1];
    for (int k = 1; k <= MAX_VARS; k++) begin
      if (n_eff == NUM_VARS_W'(k)) begin
        flags = fk[k];
      end
    end
  end

endmodule : bfpc_classify

`default_nettype wire

FILE: sv/boolean_function_post_class_checker.sv
// Post closed class checker. Each transfer on the input channel carries one
// Boolean function as a truth table with its variable count, and produces one
// result transfer with the function's membership in T0, T1, S, M and L plus the
// running class flags of the current system and its completeness. The block
// takes one function per clock cycle while the result channel is not stalled;
// a function passes through the input register and then the result register,
// with the class tests in the logic between them. A stalled result
// channel holds both registers, so up to two functions are in flight.
// ----------------------------------------------------------------------------
// Post class checker top level
// Input register, class tests, system accumulation and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module boolean_function_post_class_checker #(
  parameter int MAX_VARS = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  bfpc_in_if.sink     in_ch,
  bfpc_out_if.source  out_ch
);
  import bfpc_pkg::*;

  logic                  s1_valid_r;
  logic [NUM_VARS_W-1:0] s1_num_vars_r;
  logic [TT_W-1:0]       s1_tt_r;
  logic                  s1_new_r;

  logic                  out_valid_r;
  class_flags_t          own_r;
  class_flags_t          shared_r;
  class_flags_t          shared_nxt;
  class_flags_t          own;

  logic                  s2_ready;
  logic                  s1_ready;
  logic                  s2_load;

  bfpc_classify #(
    .MAX_VARS (MAX_VARS)
  ) u_classify (
    .num_vars    (s1_num_vars_r),
    .truth_table (s1_tt_r),
    .flags       (own)
  );

  assign s2_ready    = !out_valid_r || out_ch.ready;
  assign s1_ready    = !s1_valid_r || s2_ready;
  assign s2_load     = s1_valid_r && s2_ready;
  assign in_ch.ready = s1_ready;
  assign shared_nxt  = s1_new_r ? own : (shared_r & own);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      shared_r    <= ALL_CLASSES;
    end else begin
      if (s1_ready) begin
        s1_valid_r <= in_ch.valid;
      end
      if (s2_ready) begin
        out_valid_r <= s1_valid_r;
      end
      if (s2_load) begin
        shared_r <= shared_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && in_ch.valid) begin
      s1_num_vars_r <= in_ch.num_vars;
      s1_tt_r       <= in_ch.truth_table;
      s1_new_r      <= in_ch.new_system;
    end
    if (s2_load) begin
      own_r <= own;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.in_t0           = own_r.t0;
  assign out_ch.in_t1           = own_r.t1;
  assign out_ch.in_s            = own_r.s;
  assign out_ch.in_m            = own_r.m;
  assign out_ch.in_l            = own_r.l;
  assign out_ch.all_t0          = shared_r.t0;
  assign out_ch.all_t1          = shared_r.t1;
  assign out_ch.all_s           = shared_r.s;
  assign out_ch.all_m           = shared_r.m;
  assign out_ch.all_l           = shared_r.l;
  assign out_ch.system_complete = (shared_r == '0);

endmodule : boolean_function_post_class_checker

`default_nettype wire

FILE: sv/bfpc_checker.sv
// ----------------------------------------------------------------------------
// Post class checker assertions
// Port-level checks of the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bfpc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [4:0] own,
  input logic [4:0] shared,
  input logic       complete
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(own) && $stable(shared)
                                && $stable(complete))
    else $error("Result changed while stalled.");

  a_complete: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> complete == (shared == 5'b00000))
    else $error("Completeness disagrees with the shared flags.");

  a_shared_subset: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (shared & ~own) == 5'b00000)
    else $error("Shared flag set for a class the function lacks.");

  a_self_dual: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && own[2] |-> own[0] == own[1])
    else $error("Self-dual function with unequal T0 and T1.");

endmodule : bfpc_checker

bind boolean_function_post_class_checker bfpc_checker u_bfpc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .own       ({out_ch.in_l, out_ch.in_m, out_ch.in_s, out_ch.in_t1, out_ch.in_t0}),
  .shared    ({out_ch.all_l, out_ch.all_m, out_ch.all_s, out_ch.all_t1, out_ch.all_t0}),
  .complete  (out_ch.system_complete)
);

`default_nettype wire

FILE: verif/tb.sv
// ----------------------------------------------------------------------------
// Post class checker testbench
// Sends Boolean functions through the input channel under several idle and
// stall patterns and compares every result transfer with the class memberships
// and running system flags that a local predictor works out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import bfpc_pkg::*;

  localparam int CYCLE_LIMIT  = 200_000;
  localparam int PHASE_ITEMS  = 500;
  localparam int TAIL_CYCLES  = 8;

  typedef struct {
    logic [NUM_VARS_W-1:0] num_vars;
    logic [TT_W-1:0]       truth_table;
    logic                  new_system;
  } fn_item_t;

  typedef struct packed {
    class_flags_t own;
    class_flags_t shared;
    logic         complete;
  } class_result_t;

  class post_class_sb;
    class_flags_t  system_flags;
    class_result_t expected_results[$];
    int            error_count;

    function new();
      system_flags = ALL_CLASSES;
      error_count  = 0;
    endfunction

    function class_flags_t post_classes(input logic [NUM_VARS_W-1:0] nv,
                                        input logic [TT_W-1:0] tt_in);
      int           n;
      int           size;
      int           top;
      logic [15:0]  tt;
      logic [15:0]  anf;
      class_flags_t f;
      n = nv;
      if (n < 1) n = 1;
      if (n > 4) n = 4;
      size = 1 << n;
      top  = size - 1;
      tt   = tt_in & 16'((1 << size) - 1);
      f.t0 = !tt[0];
      f.t1 = tt[top];
      f.s  = 1'b1;
      f.m  = 1'b1;
      f.l  = 1'b1;
      for (int i = 0; i < size; i++) begin
        if (tt[i] == tt[top ^ i]) f.s = 1'b0;
        for (int j = 0; j < size; j++) begin
          if ((i & j) == i && tt[i] && !tt[j]) f.m = 1'b0;
        end
      end
      // The Moebius transform gives the Zhegalkin coefficients.
      anf = tt;
      for (int b = 0; b < n; b++) begin
        for (int i = 0; i < size; i++) begin
          if ((i >> b) & 1) anf[i] = anf[i] ^ anf[i ^ (1 << b)];
        end
      end
      for (int i = 0; i < size; i++) begin
        if ($countones(i) >= 2 && anf[i]) f.l = 1'b0;
      end
      return f;
    endfunction

    function void note_function(input fn_item_t it);
      class_result_t r;
      r.own = post_classes(it.num_vars, it.truth_table);
      if (it.new_system) system_flags = r.own;
      else system_flags = system_flags & r.own;
      r.shared   = system_flags;
      r.complete = (system_flags == '0);
      expected_results = {expected_results, r};
    endfunction

    function void compare_bit(input string field, input logic exp_v, input logic act_v);
      if (exp_v !== act_v) begin
        $error("%s expected %0b actual %0b", field, exp_v, act_v);
        error_count++;
      end
    endfunction

    function void check_result(input class_result_t act);
      class_result_t e;
      if (expected_results.size() == 0) begin
        $error("result transfer with no expected result waiting");
        error_count++;
        return;
      end
      e = expected_results.pop_front();
      compare_bit("in_t0", e.own.t0, act.own.t0);
      compare_bit("in_t1", e.own.t1, act.own.t1);
      compare_bit("in_s", e.own.s, act.own.s);
      compare_bit("in_m", e.own.m, act.own.m);
      compare_bit("in_l", e.own.l, act.own.l);
      compare_bit("all_t0", e.shared.t0, act.shared.t0);
      compare_bit("all_t1", e.shared.t1, act.shared.t1);
      compare_bit("all_s", e.shared.s, act.shared.s);
      compare_bit("all_m", e.shared.m, act.shared.m);
      compare_bit("all_l", e.shared.l, act.shared.l);
      compare_bit("system_complete", e.complete, act.complete);
    endfunction

    function int pending();
      return expected_results.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  int   sender_idle_pct;
  int   receiver_stall_pct;
  int   cycle_count;
  post_class_sb sb;

  bfpc_in_if  in_ch ();
  bfpc_out_if out_ch ();

  boolean_function_post_class_checker u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_ch.ready = ($urandom_range(99) >= receiver_stall_pct);
  end

  always @(posedge clk) begin
    class_result_t act;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      act.own.t0      = out_ch.in_t0;
      act.own.t1      = out_ch.in_t1;
      act.own.s       = out_ch.in_s;
      act.own.m       = out_ch.in_m;
      act.own.l       = out_ch.in_l;
      act.shared.t0   = out_ch.all_t0;
      act.shared.t1   = out_ch.all_t1;
      act.shared.s    = out_ch.all_s;
      act.shared.m    = out_ch.all_m;
      act.shared.l    = out_ch.all_l;
      act.complete    = out_ch.system_complete;
      sb.check_result(act);
    end
  end

  task automatic send_function(input fn_item_t it);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid       = 1'b1;
    in_ch.num_vars    = it.num_vars;
    in_ch.truth_table = it.truth_table;
    in_ch.new_system  = it.new_system;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_function(it);
    @(negedge clk);
  endtask

  task automatic send_table(input int nv, input int tt, input bit fresh);
    fn_item_t it;
    it.num_vars    = nv[NUM_VARS_W-1:0];
    it.truth_table = tt[TT_W-1:0];
    it.new_system  = fresh;
    send_function(it);
  endtask

  task automatic drain_results();
    in_ch.valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  function automatic fn_item_t random_function();
    fn_item_t    it;
    int          n;
    int          size;
    int          top;
    int          kind;
    logic [3:0]  coef;
    logic        c0;
    logic [3:0]  terms[3];
    int          num_terms;
    logic        hit;
    n = ($urandom_range(15) == 0) ? $urandom_range(0, 7) : $urandom_range(1, 4);
    it.num_vars = n[NUM_VARS_W-1:0];
    if (n < 1) n = 1;
    if (n > 4) n = 4;
    size = 1 << n;
    top  = size - 1;
    it.truth_table = TT_W'($urandom);
    it.new_system  = ($urandom_range(3) == 0);
    kind = $urandom_range(9);
    case (kind)
      3, 4: begin
        coef = 4'($urandom_range(0, top));
        c0   = 1'($urandom_range(1));
        for (int i = 0; i < size; i++) it.truth_table[i] = c0 ^ (^(4'(i) & coef));
      end
      5: begin
        for (int i = 0; i < size; i++) begin
          if (i < (top ^ i)) begin
            it.truth_table[i]       = 1'($urandom_range(1));
            it.truth_table[top ^ i] = !it.truth_table[i];
          end
        end
      end
      6, 7: begin
        num_terms = $urandom_range(0, 3);
        for (int k = 0; k < 3; k++) terms[k] = 4'($urandom_range(0, top));
        for (int i = 0; i < size; i++) begin
          hit = 1'b0;
          for (int k = 0; k < num_terms; k++) begin
            if ((4'(i) & terms[k]) == terms[k]) hit = 1'b1;
          end
          it.truth_table[i] = hit;
        end
      end
      8: begin
        c0 = 1'($urandom_range(1));
        for (int i = 0; i < size; i++) it.truth_table[i] = c0;
      end
      default: begin
      end
    endcase
    return it;
  endfunction

  initial begin
    rst_n              = 1'b0;
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    in_ch.valid        = 1'b0;
    in_ch.num_vars     = '0;
    in_ch.truth_table  = '0;
    in_ch.new_system   = 1'b0;
    sb = new();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Without a system start after reset the first functions fold into the all-ones reset flags.
    send_table(4, 'h0000, 0);
    send_table(4, 'hFFFF, 0);
    send_table(0, 'h0002, 1);
    send_table(7, 'hFF00, 0);
    send_table(5, 'h00FF, 1);
    send_table(6, 'hF0F0, 0);
    send_table(1, 'hFFFE, 1);
    send_table(1, 'h0001, 0);
    send_table(2, 'h0008, 1);
    send_table(2, 'h000E, 0);
    send_table(2, 'h0006, 0);
    send_table(3, 'h00E8, 1);
    send_table(3, 'h0096, 0);
    send_table(4, 'h6996, 1);
    send_table(4, 'h8000, 0);
    send_table(2, 'h0007, 1);
    send_table(3, 'hFF17, 0);
    send_table(4, 'hFFFE, 1);
    send_table(4, 'h0001, 0);
    send_table(0, 'hAAAA, 1);
    drain_results();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        1: begin sender_idle_pct = 85; receiver_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  receiver_stall_pct = 85; end
        default: begin sender_idle_pct = 26; receiver_stall_pct = 26; end
      endcase
      for (int k = 0; k < PHASE_ITEMS; k++) send_function(random_function());
      drain_results();
    end

    in_ch.valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.error_count == 0 && sb.pending() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

FILE: filelist.f
sv/bfpc_pkg.sv
sv/bfpc_if.sv
sv/bfpc_classify.sv
sv/boolean_function_post_class_checker.sv
sv/bfpc_checker.sv
verif/tb.sv
